// File: sv/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// File: sv/cbm_pkg.sv
// shared types, constants and write decode for the bank mapper
// no dependencies
package cbm_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_PRG_BANK = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_PRESENT   = 1'b1;

   localparam logic [CSR_DATA_W-1:0] LAST_PRG_BANK_RESET = 6'd63;

   localparam logic [3:0] GRP_PRG    = 4'h8;
   localparam logic [3:0] GRP_PRG_HI = 4'h9;
   localparam logic [3:0] GRP_CHR_A  = 4'hA;
   localparam logic [3:0] GRP_CHR_B  = 4'hB;
   localparam logic [3:0] GRP_CHR_C  = 4'hC;
   localparam logic [3:0] GRP_CHR_D  = 4'hD;
   localparam logic [3:0] GRP_RELOAD = 4'hE;
   localparam logic [3:0] GRP_IRQ    = 4'hF;

   // low address bits that pick a register within a group
   localparam logic [1:0] IRQ_RELOAD_LOW = 2'd0;
   localparam logic [1:0] IRQ_CTRL_LOW   = 2'd1;
   localparam logic [1:0] MIRROR_LOW     = 2'd2;
   localparam logic [1:0] RAM_EN_LOW     = 2'd2;
   localparam logic [1:0] SPARE_LOW      = 2'd3;

   typedef enum logic [1:0] {
      KIND_CPU_WRITE  = 2'd0,
      KIND_TICK       = 2'd1,
      KIND_CPU_LOOKUP = 2'd2,
      KIND_PPU_LOOKUP = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_PRG,
      SEL_RAM_EN,
      SEL_CHR,
      SEL_RELOAD,
      SEL_IRQ_RELOAD,
      SEL_IRQ_CTRL,
      SEL_MIRROR
   } sel_type;

   // item entering the processing stage
   typedef struct packed {
      logic        fire;
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  data;
   } item_type;

   typedef struct packed {
      logic [7:0] bank;
      logic       bank_valid;
      logic       ram_write;
      logic [1:0] mirroring;
   } bank_res_type;

   // register select for a cpu write, decoded on address & f003
   function automatic sel_type decode_write(logic [15:0] address);
      logic [3:0] grp;
      logic [1:0] low;
      sel_type    sel;
      grp = address[15:12];
      low = address[1:0];
      sel = SEL_NONE;
      unique case (grp) inside
         GRP_PRG:    sel = SEL_PRG;
         GRP_PRG_HI: sel = (low == RAM_EN_LOW) ? SEL_RAM_EN :
                           ((low == SPARE_LOW) ? SEL_NONE : SEL_PRG);
         GRP_CHR_A, GRP_CHR_B, GRP_CHR_C, GRP_CHR_D: sel = SEL_CHR;
         GRP_RELOAD: sel = SEL_RELOAD;
         GRP_IRQ: begin
            unique case (low)
               IRQ_RELOAD_LOW: sel = SEL_IRQ_RELOAD;
               IRQ_CTRL_LOW:   sel = SEL_IRQ_CTRL;
               MIRROR_LOW:     sel = SEL_MIRROR;
               default:        sel = SEL_NONE;
            endcase
         end
         default: sel = SEL_NONE;
      endcase
      return sel;
   endfunction

endpackage

// File: sv/cbm_irq_counter.sv
// irq down-counter with nibble reload, masked width and pending flag
// depends on cbm_pkg
module cbm_irq_counter (
   input  logic              clock,
   input  logic              reset,
   input  cbm_pkg::item_type item,
   output logic              irq_pending_next
);

   logic [3:0]  reload_ff [4];
   logic [3:0]  reload_in [4];
   logic [15:0] count_ff, count_in;
   logic [15:0] mask_ff, mask_in;
   logic        on_ff, on_in;
   logic        pending_ff, pending_in;
   logic [15:0] part;
   cbm_pkg::sel_type sel;

   always_comb begin
      sel        = cbm_pkg::decode_write(item.address);
      reload_in  = reload_ff;
      count_in   = count_ff;
      mask_in    = mask_ff;
      on_in      = on_ff;
      pending_in = pending_ff;
      part       = (count_ff & mask_ff) - 16'd1;
      if (item.fire) begin
         case (item.kind)
            cbm_pkg::KIND_CPU_WRITE: begin
               if (item.address[15]) begin
                  case (sel)
                     cbm_pkg::SEL_RELOAD: reload_in[item.address[1:0]] = item.data[3:0];
                     cbm_pkg::SEL_IRQ_RELOAD: begin
                        pending_in = 1'b0;
                        count_in   = {reload_ff[3], reload_ff[2], reload_ff[1], reload_ff[0]};
                     end
                     cbm_pkg::SEL_IRQ_CTRL: begin
                        pending_in = 1'b0;
                        on_in      = item.data[0];
                        // narrowest width wins
                        if (item.data[3])      mask_in = 16'h000F;
                        else if (item.data[2]) mask_in = 16'h00FF;
                        else if (item.data[1]) mask_in = 16'h0FFF;
                        else                   mask_in = 16'hFFFF;
                     end
                     default: ;
                  endcase
               end
            end
            cbm_pkg::KIND_TICK: begin
               if (on_ff) begin
                  if (part == 16'd0) pending_in = 1'b1;
                  count_in = (count_ff & ~mask_ff) | (part & mask_ff);
               end
            end
            default: ;
         endcase
      end
   end

   assign irq_pending_next = pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) reload_ff[i] <= 4'd0;
         count_ff   <= 16'd0;
         mask_ff    <= 16'd0;
         on_ff      <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         reload_ff  <= reload_in;
         count_ff   <= count_in;
         mask_ff    <= mask_in;
         on_ff      <= on_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// File: sv/cbm_bank_regs.sv
// prg/chr bank nibbles, ram enable, mirroring and bank lookup
// depends on cbm_pkg
module cbm_bank_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cbm_pkg::item_type                    item,
   input  logic                                 csr_write,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]       csr_data,
   output cbm_pkg::bank_res_type                res
);

   // nibbles kept as low/high pairs so each lookup reads one entry
   logic [3:0] prg_lo_ff [3];
   logic [1:0] prg_hi_ff [3];
   logic [3:0] chr_lo_ff [8];
   logic [3:0] chr_hi_ff [8];
   logic [3:0] prg_lo_in [3];
   logic [1:0] prg_hi_in [3];
   logic [3:0] chr_lo_in [8];
   logic [3:0] chr_hi_in [8];
   logic       ram_on_ff, ram_on_in;
   logic [1:0] mirror_ff, mirror_in;
   logic [cbm_pkg::CSR_DATA_W-1:0] last_prg_ff;
   logic       ram_present_ff;
   cbm_pkg::sel_type sel;
   logic [1:0] prg_pair;
   logic [1:0] chr_grp;
   logic [2:0] chr_pair;
   logic [1:0] win;
   logic [2:0] chr_n;

   always_comb begin
      sel       = cbm_pkg::decode_write(item.address);
      prg_pair  = (item.address[15:12] == cbm_pkg::GRP_PRG) ? {1'b0, item.address[1]} : 2'd2;
      chr_grp   = 2'(item.address[13:12] - 2'd2);
      chr_pair  = {chr_grp, item.address[1]};
      win       = item.address[14:13];
      chr_n     = item.address[12:10];
      prg_lo_in = prg_lo_ff;
      prg_hi_in = prg_hi_ff;
      chr_lo_in = chr_lo_ff;
      chr_hi_in = chr_hi_ff;
      ram_on_in = ram_on_ff;
      mirror_in = mirror_ff;
      res       = '0;
      if (item.fire) begin
         case (item.kind)
            cbm_pkg::KIND_CPU_WRITE: begin
               if (item.address[15:13] == 3'b011) begin
                  res.ram_write = ram_on_ff & ram_present_ff;
               end else if (item.address[15]) begin
                  case (sel)
                     cbm_pkg::SEL_PRG: begin
                        if (item.address[0]) prg_hi_in[prg_pair] = item.data[1:0];
                        else                 prg_lo_in[prg_pair] = item.data[3:0];
                     end
                     cbm_pkg::SEL_CHR: begin
                        if (item.address[0]) chr_hi_in[chr_pair] = item.data[3:0];
                        else                 chr_lo_in[chr_pair] = item.data[3:0];
                     end
                     cbm_pkg::SEL_RAM_EN: ram_on_in = |item.data[1:0];
                     cbm_pkg::SEL_MIRROR: mirror_in = item.data[1:0];
                     default: ;
                  endcase
               end
            end
            cbm_pkg::KIND_CPU_LOOKUP: begin
               if (item.address[15]) begin
                  res.bank_valid = 1'b1;
                  if (win == 2'd3) res.bank = {2'b00, last_prg_ff};
                  else             res.bank = {2'b00, prg_hi_ff[win], prg_lo_ff[win]};
               end
            end
            cbm_pkg::KIND_PPU_LOOKUP: begin
               if (item.address[15:13] == 3'b000) begin
                  res.bank_valid = 1'b1;
                  res.bank       = {chr_hi_ff[chr_n], chr_lo_ff[chr_n]};
               end
            end
            default: ;
         endcase
      end
      res.mirroring = mirror_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            prg_lo_ff[i] <= 4'd0;
            prg_hi_ff[i] <= 2'd0;
         end
         for (int i = 0; i < 8; i++) begin
            chr_lo_ff[i] <= 4'd0;
            chr_hi_ff[i] <= 4'd0;
         end
         ram_on_ff      <= 1'b1;
         mirror_ff      <= 2'd0;
         last_prg_ff    <= cbm_pkg::LAST_PRG_BANK_RESET;
         ram_present_ff <= 1'b1;
      end else begin
         prg_lo_ff <= prg_lo_in;
         prg_hi_ff <= prg_hi_in;
         chr_lo_ff <= chr_lo_in;
         chr_hi_ff <= chr_hi_in;
         ram_on_ff <= ram_on_in;
         mirror_ff <= mirror_in;
         if (csr_write) begin
            unique case (csr_index)
               cbm_pkg::CSR_LAST_PRG_BANK: last_prg_ff    <= csr_data;
               cbm_pkg::CSR_RAM_PRESENT:   ram_present_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: sv/cartridge_bank_mapper_irq_counter_unit.sv
// path: a word taken into the input register moves on to the result register
// throughput: one word per clock unless a stalled result register is full; the state
//   update sits in a single stage between the input register and the result register
// reset: synchronous, active high; clears bank nibbles, counter, mask and irq,
//   sets ram enable, last prg bank to 63 and ram present to 1
// depends on cbm_pkg, cbm_irq_counter, cbm_bank_regs and assert_macros.svh
`include "assert_macros.svh"
module cartridge_bank_mapper_irq_counter_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request words
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [15:0]                     req_address,
   input  logic [7:0]                      req_data,
   // result words
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_irq_level,
   output logic [7:0]                      rsp_bank,
   output logic                            rsp_bank_valid,
   output logic                            rsp_ram_write,
   output logic [1:0]                      rsp_mirroring,
   // configuration writes
   input  logic                            csr_write,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]  csr_data
);

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic [15:0] s1_address_ff;
   logic [7:0]  s1_data_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_irq_ff;
   logic [7:0]  rsp_bank_ff;
   logic        rsp_bank_valid_ff;
   logic        rsp_ram_write_ff;
   logic [1:0]  rsp_mirroring_ff;

   logic advance;
   logic fire;
   logic req_take;
   logic irq_next;
   logic irq_ack_fire;
   logic rsp_miss;
   cbm_pkg::item_type     item;
   cbm_pkg::bank_res_type bank_res;

   // the stage moves on when the result register is empty or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item.fire    = fire;
      item.kind    = cbm_pkg::kind_type'(s1_kind_ff);
      item.address = s1_address_ff;
      item.data    = s1_data_ff;
   end

   cbm_irq_counter u_irq (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .irq_pending_next (irq_next)
   );

   cbm_bank_regs u_bank (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .res       (bank_res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)  s1_valid_in = 1'b1;
      else if (fire) s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (fire)               rsp_valid_in = 1'b1;
      else if (!rsp_stall)    rsp_valid_in = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff    <= req_kind;
         s1_address_ff <= req_address;
         s1_data_ff    <= req_data;
      end
      if (fire) begin
         rsp_irq_ff        <= irq_next;
         rsp_bank_ff       <= bank_res.bank;
         rsp_bank_valid_ff <= bank_res.bank_valid;
         rsp_ram_write_ff  <= bank_res.ram_write;
         rsp_mirroring_ff  <= bank_res.mirroring;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_irq_level  = rsp_irq_ff;
   assign rsp_bank       = rsp_bank_ff;
   assign rsp_bank_valid = rsp_bank_valid_ff;
   assign rsp_ram_write  = rsp_ram_write_ff;
   assign rsp_mirroring  = rsp_mirroring_ff;

   // f000 or f001 write being processed
   assign irq_ack_fire = fire && s1_kind_ff == cbm_pkg::KIND_CPU_WRITE &&
                         s1_address_ff[15:12] == cbm_pkg::GRP_IRQ && !s1_address_ff[1];
   assign rsp_miss     = rsp_valid && !rsp_bank_valid;

   // a word leaving the input register always lands in the result register
   `ASSERT_NEXT(a_fire_lands, clock, reset, fire, rsp_valid, "processed word not presented")
   // stall only while the input register holds a word
   `ASSERT_IMPLIES(a_stall_full, clock, reset, req_stall, s1_valid_ff, "stall with empty stage")
   // a miss never carries a bank number
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_miss, rsp_bank == 8'd0, "bank on miss")
   // reload or control write acknowledges the irq
   `ASSERT_NEXT(a_irq_ack, clock, reset, irq_ack_fire, !rsp_irq_level, "irq not acknowledged")

endmodule

// File: tb/tb_cartridge_bank_mapper_irq_counter_unit.sv
// self-checking testbench for the cartridge bank mapper with its irq down-counter
// drives request words through the valid/stall channel and checks every result word
// against a predictor kept inside this file; depends on cbm_pkg and the unit itself
module tb_cartridge_bank_mapper_irq_counter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // result word as the unit presents it
   typedef struct packed {
      logic       irq_level;
      logic [7:0] bank;
      logic       bank_valid;
      logic       ram_write;
      logic [1:0] mirroring;
   } rsp_word_type;

   // one line of the directed stimulus; typed rows carry their own expectation
   typedef struct {
      cbm_pkg::kind_type kind;
      logic [15:0]       address;
      logic [7:0]        data;
      bit                typed;
      rsp_word_type      expected;
   } dir_row_type;

   localparam rsp_word_type IDLE_WORD   = '0;
   localparam int           HOLD_CYCLES = 200;
   localparam int           CYCLE_LIMIT = 200000;
   localparam int           DIR_ROWS    = 25;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [1:0]                      req_kind;
   logic [15:0]                     req_address;
   logic [7:0]                      req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_irq_level;
   logic [7:0]                      rsp_bank;
   logic                            rsp_bank_valid;
   logic                            rsp_ram_write;
   logic [1:0]                      rsp_mirroring;
   logic                            csr_write;
   logic [cbm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cbm_pkg::CSR_DATA_W-1:0]  csr_data;

   cartridge_bank_mapper_irq_counter_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_irq_level  (rsp_irq_level),
      .rsp_bank       (rsp_bank),
      .rsp_bank_valid (rsp_bank_valid),
      .rsp_ram_write  (rsp_ram_write),
      .rsp_mirroring  (rsp_mirroring),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // mapper state as the predictor sees it
   // ---------------------------------------------------------------------------
   logic [3:0]  prg_nib [6];
   logic [3:0]  chr_nib [16];
   logic [3:0]  reload_nib [4];
   logic [15:0] irq_count;
   logic [15:0] count_mask;
   logic        irq_on;
   logic        irq_pend;
   logic        ram_on;
   logic [1:0]  mirror;
   logic [5:0]  cfg_last_bank;
   logic        cfg_ram_present;

   rsp_word_type expected_words [$];

   int          n_sent;
   int          n_checked;
   int          n_irq_rises;
   int          n_lookups;
   int          n_settings;
   int          mismatches;
   int          cycle_count;

   // idling control shared between the sender, the receiver and the sequencer
   bit          sender_calm;
   bit          receiver_calm;
   bit          hold_results;

   // advance the mapper state by one request word and work out its result word
   function automatic rsp_word_type mapper_response(cbm_pkg::kind_type k, logic [15:0] a,
                                                    logic [7:0] d);
      rsp_word_type r;
      logic [15:0]  part;
      logic [3:0]   grp;
      logic [3:0]   chr_grp;
      logic [1:0]   low;
      logic         was_pending;
      logic [1:0]   w;
      logic [2:0]   n;
      r           = IDLE_WORD;
      grp         = a[15:12];
      low         = a[1:0];
      chr_grp     = grp - cbm_pkg::GRP_CHR_A;
      was_pending = irq_pend;
      case (k)
         cbm_pkg::KIND_CPU_WRITE: begin
            if (a >= 16'h6000 && a < 16'h8000) begin
               r.ram_write = ram_on & cfg_ram_present;
            end else if (a[15]) begin
               // only address & f003 takes part in the decode
               case (grp) inside
                  cbm_pkg::GRP_PRG: prg_nib[{1'b0, low}] = d[3:0];
                  cbm_pkg::GRP_PRG_HI: begin
                     if (!low[1]) prg_nib[{2'b10, low[0]}] = d[3:0];
                     else if (low == cbm_pkg::RAM_EN_LOW) ram_on = (d[1:0] != 2'd0);
                  end
                  cbm_pkg::GRP_CHR_A, cbm_pkg::GRP_CHR_B,
                  cbm_pkg::GRP_CHR_C, cbm_pkg::GRP_CHR_D: begin
                     chr_nib[{chr_grp[1:0], low}] = d[3:0];
                  end
                  cbm_pkg::GRP_RELOAD: reload_nib[low] = d[3:0];
                  cbm_pkg::GRP_IRQ: begin
                     case (low)
                        cbm_pkg::IRQ_RELOAD_LOW: begin
                           irq_pend  = 1'b0;
                           irq_count = {reload_nib[3], reload_nib[2],
                                        reload_nib[1], reload_nib[0]};
                        end
                        cbm_pkg::IRQ_CTRL_LOW: begin
                           irq_pend   = 1'b0;
                           irq_on     = d[0];
                           count_mask = d[3] ? 16'h000F : d[2] ? 16'h00FF :
                                        d[1] ? 16'h0FFF : 16'hFFFF;
                        end
                        cbm_pkg::MIRROR_LOW: mirror = d[1:0];
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         cbm_pkg::KIND_TICK: begin
            // only the masked part counts; a masked zero wraps without an irq
            if (irq_on) begin
               part = (irq_count & count_mask) - 16'd1;
               if (part == 16'd0) irq_pend = 1'b1;
               irq_count = (irq_count & ~count_mask) | (part & count_mask);
            end
         end
         cbm_pkg::KIND_CPU_LOOKUP: begin
            if (a[15]) begin
               w            = a[14:13];
               r.bank_valid = 1'b1;
               if (w == 2'd3) r.bank = {2'b00, cfg_last_bank};
               else           r.bank = {2'b00, prg_nib[{w, 1'b1}][1:0], prg_nib[{w, 1'b0}]};
            end
         end
         default: begin
            if (a < 16'h2000) begin
               n            = a[12:10];
               r.bank_valid = 1'b1;
               r.bank       = {chr_nib[{n, 1'b1}], chr_nib[{n, 1'b0}]};
            end
         end
      endcase
      if (irq_pend && !was_pending) n_irq_rises++;
      if (r.bank_valid) n_lookups++;
      r.irq_level = irq_pend;
      r.mirroring = mirror;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // sender: one request word per call, with a random gap in front of it
   // ---------------------------------------------------------------------------
   task automatic send_word(cbm_pkg::kind_type k, logic [15:0] a, logic [7:0] d,
                            bit typed = 1'b0, rsp_word_type typed_exp = '0);
      int           gap;
      rsp_word_type predicted;
      gap = sender_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= k;
      req_address <= a;
      req_data    <= d;
      // the word goes in at the first edge that sees no stall
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = mapper_response(k, a, d);
      expected_words.push_back(typed ? typed_exp : predicted);
      n_sent++;
   endtask

   // let everything in flight come out, with the input channel quiet
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // configuration write, only while the unit is idle
   task automatic write_csr(logic [cbm_pkg::CSR_INDEX_W-1:0] idx,
                            logic [cbm_pkg::CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == cbm_pkg::CSR_LAST_PRG_BANK) cfg_last_bank = value;
      else                                   cfg_ram_present = value[0];
      n_settings++;
   endtask

   // register address with random don't-care bits in the middle
   function automatic logic [15:0] reg_addr(logic [3:0] grp, logic [1:0] low);
      logic [9:0] mid;
      mid = 10'($urandom);
      return {grp, mid, low};
   endfunction

   // mostly rom-window lookups, now and then one that misses
   task automatic send_lookup();
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(0, 1)) begin
         if ($urandom_range(0, 3) != 0) a[15] = 1'b1;
         send_word(cbm_pkg::KIND_CPU_LOOKUP, a, 8'($urandom));
      end else begin
         if ($urandom_range(0, 3) != 0) a[15:13] = 3'b000;
         send_word(cbm_pkg::KIND_PPU_LOOKUP, a, 8'($urandom));
      end
   endtask

   // load reload nibbles, arm the counter at a random width and tick it down
   task automatic program_counter();
      int         width;
      int         nticks;
      logic [3:0] nib;
      logic [3:0] junk;
      logic [7:0] ctrl;
      width = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         // small masked value so that the irq is reached within a few ticks
         if (i > width)   nib = 4'($urandom);
         else if (i == 0) nib = 4'($urandom_range(0, 7));
         else             nib = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd0;
         junk = 4'($urandom);
         send_word(cbm_pkg::KIND_CPU_WRITE, reg_addr(cbm_pkg::GRP_RELOAD, 2'(i)), {junk, nib});
      end
      if ($urandom_range(0, 5) != 0)
         send_word(cbm_pkg::KIND_CPU_WRITE,
                   reg_addr(cbm_pkg::GRP_IRQ, cbm_pkg::IRQ_RELOAD_LOW), 8'($urandom));
      ctrl    = 8'($urandom);
      ctrl[0] = ($urandom_range(0, 7) != 0);
      case (width)
         0:       ctrl[3]   = 1'b1;
         1:       ctrl[3:2] = 2'b01;
         2:       ctrl[3:1] = 3'b001;
         default: ctrl[3:1] = 3'b000;
      endcase
      send_word(cbm_pkg::KIND_CPU_WRITE, reg_addr(cbm_pkg::GRP_IRQ, cbm_pkg::IRQ_CTRL_LOW), ctrl);
      nticks = $urandom_range(0, 14);
      repeat (nticks) begin
         if ($urandom_range(0, 3) == 0) send_lookup();
         send_word(cbm_pkg::KIND_TICK, 16'($urandom), 8'($urandom));
      end
      // acknowledge by either of the two irq registers, or leave it pending
      case ($urandom_range(0, 3))
         0:       send_word(cbm_pkg::KIND_CPU_WRITE,
                            reg_addr(cbm_pkg::GRP_IRQ, cbm_pkg::IRQ_RELOAD_LOW), 8'($urandom));
         1:       send_word(cbm_pkg::KIND_CPU_WRITE,
                            reg_addr(cbm_pkg::GRP_IRQ, cbm_pkg::IRQ_CTRL_LOW), 8'($urandom));
         default: ;
      endcase
   endtask

   // random part: well-formed sequences with random content, plus some noise
   task automatic run_random(int count);
      int          start;
      int          n;
      logic [3:0]  grp;
      logic [15:0] a;
      start = n_sent;
      while (n_sent - start < count) begin
         if ($urandom_range(0, 7) == 0) sender_calm   = !sender_calm;
         if ($urandom_range(0, 7) == 0) receiver_calm = !receiver_calm;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: program_counter();
            4, 5: begin
               n = $urandom_range(1, 6);
               repeat (n) begin
                  grp = cbm_pkg::GRP_PRG + 4'($urandom_range(0, 5));
                  send_word(cbm_pkg::KIND_CPU_WRITE, reg_addr(grp, 2'($urandom)), 8'($urandom));
               end
               n = $urandom_range(2, 5);
               repeat (n) send_lookup();
            end
            6: begin
               send_word(cbm_pkg::KIND_CPU_WRITE,
                         reg_addr(cbm_pkg::GRP_PRG_HI, cbm_pkg::RAM_EN_LOW), 8'($urandom));
               n = $urandom_range(1, 3);
               repeat (n) begin
                  a = {3'b011, 13'($urandom)};
                  send_word(cbm_pkg::KIND_CPU_WRITE, a, 8'($urandom));
               end
            end
            7: begin
               case ($urandom_range(0, 3))
                  0:       a = reg_addr(cbm_pkg::GRP_IRQ, cbm_pkg::MIRROR_LOW);
                  1:       a = reg_addr(cbm_pkg::GRP_IRQ, cbm_pkg::SPARE_LOW);
                  2:       a = reg_addr(cbm_pkg::GRP_PRG_HI, cbm_pkg::SPARE_LOW);
                  default: a = 16'($urandom_range(0, 16'h5FFF));
               endcase
               send_word(cbm_pkg::KIND_CPU_WRITE, a, 8'($urandom));
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) send_word(cbm_pkg::kind_type'($urandom_range(0, 3)),
                                    16'($urandom), 8'($urandom));
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------
   // receiver: random stall per result word, and one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin
      int n;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_results) begin
            // long hold so that the unit fills up and stalls its input
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
         n = receiver_calm ? 0 : $urandom_range(0, 9);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------------------
   // result checker: every accepted word against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_irq_level, rsp_bank, rsp_bank_valid, rsp_ram_write, rsp_mirroring};
         if (expected_words.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: irq %0b bank %02h valid %0b ramw %0b mirr %0d",
                        got.irq_level, got.bank, got.bank_valid, got.ram_write, got.mirroring);
            mismatches++;
         end else begin
            exp = expected_words.pop_front();
            if (got.irq_level !== exp.irq_level || got.bank !== exp.bank ||
                got.bank_valid !== exp.bank_valid || got.ram_write !== exp.ram_write ||
                got.mirroring !== exp.mirroring) begin
               if (mismatches < 10) begin
                  $write("mismatch on result %0d: exp irq %0b bank %02h valid %0b ramw %0b",
                         n_checked, exp.irq_level, exp.bank, exp.bank_valid, exp.ram_write);
                  $display(" mirr %0d, got irq %0b bank %02h valid %0b ramw %0b mirr %0d",
                           exp.mirroring, got.irq_level, got.bank, got.bank_valid,
                           got.ram_write, got.mirroring);
               end
               mismatches++;
            end
            n_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_words.size());
         $display("tb_cartridge_bank_mapper_irq_counter_unit failed");
         $finish;
      end
   end

   // directed rows: reset values, window edges, masking and one full irq cycle
   dir_row_type dir_rows [DIR_ROWS] = '{
      // fixed top window straight after reset
      '{cbm_pkg::KIND_CPU_LOOKUP, 16'hE000, 8'h00, 1'b1, '{1'b0, 8'd63, 1'b1, 1'b0, 2'd0}},
      // work ram and the ppu name tables are not rom
      '{cbm_pkg::KIND_CPU_LOOKUP, 16'h7FFF, 8'hFF, 1'b1, IDLE_WORD},
      '{cbm_pkg::KIND_PPU_LOOKUP, 16'h2000, 8'h00, 1'b1, IDLE_WORD},
      '{cbm_pkg::KIND_PPU_LOOKUP, 16'h0000, 8'h00, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b0, 2'd0}},
      // ram enabled and present out of reset
      '{cbm_pkg::KIND_CPU_WRITE,  16'h6000, 8'h00, 1'b1, '{1'b0, 8'd0, 1'b0, 1'b1, 2'd0}},
      // write below the ram window goes nowhere
      '{cbm_pkg::KIND_CPU_WRITE,  16'h5FFF, 8'hFF, 1'b1, IDLE_WORD},
      // counter still disabled
      '{cbm_pkg::KIND_TICK,       16'hFFFF, 8'hFF, 1'b1, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_WRITE,  16'h8000, 8'hFF, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_WRITE,  16'h8001, 8'hFF, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_LOOKUP, 16'h8000, 8'h00, 1'b0, IDLE_WORD},
      // 9ffd decodes as 9001
      '{cbm_pkg::KIND_CPU_WRITE,  16'h9FFD, 8'hA6, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_LOOKUP, 16'hBFFF, 8'h00, 1'b0, IDLE_WORD},
      // dfff decodes as d003, the top chr nibble
      '{cbm_pkg::KIND_CPU_WRITE,  16'hDFFF, 8'hFF, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_PPU_LOOKUP, 16'h1FFF, 8'h00, 1'b0, IDLE_WORD},
      // ram off: low two bits clear
      '{cbm_pkg::KIND_CPU_WRITE,  16'h9002, 8'hFC, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_WRITE,  16'h7FFF, 8'h55, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_WRITE,  16'hF002, 8'hFF, 1'b0, IDLE_WORD},
      // reload nibbles keep only their low four bits
      '{cbm_pkg::KIND_CPU_WRITE,  16'hE000, 8'hF2, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_WRITE,  16'hE003, 8'hFF, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_CPU_WRITE,  16'hF000, 8'h00, 1'b0, IDLE_WORD},
      // enable at 4-bit width
      '{cbm_pkg::KIND_CPU_WRITE,  16'hF001, 8'h09, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_TICK,       16'h0000, 8'h00, 1'b0, IDLE_WORD},
      '{cbm_pkg::KIND_TICK,       16'h0000, 8'h00, 1'b0, IDLE_WORD},
      // masked zero wraps, irq stays up
      '{cbm_pkg::KIND_TICK,       16'h0000, 8'h00, 1'b0, IDLE_WORD},
      // acknowledge
      '{cbm_pkg::KIND_CPU_WRITE,  16'hF001, 8'h00, 1'b0, IDLE_WORD}
   };

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   initial begin
      logic [cbm_pkg::CSR_DATA_W-1:0] junk;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = cbm_pkg::KIND_CPU_WRITE;
      req_address = '0;
      req_data    = '0;
      csr_write   = 1'b0;
      csr_index   = cbm_pkg::CSR_LAST_PRG_BANK;
      csr_data    = '0;
      n_sent      = 0;
      n_checked   = 0;
      n_irq_rises = 0;
      n_lookups   = 0;
      n_settings  = 0;
      mismatches  = 0;
      cycle_count = 0;
      hold_results  = 1'b0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;

      // predictor state after reset
      foreach (prg_nib[i])    prg_nib[i]    = '0;
      foreach (chr_nib[i])    chr_nib[i]    = '0;
      foreach (reload_nib[i]) reload_nib[i] = '0;
      irq_count       = '0;
      count_mask      = '0;
      irq_on          = 1'b0;
      irq_pend        = 1'b0;
      ram_on          = 1'b1;
      mirror          = '0;
      cfg_last_bank   = cbm_pkg::LAST_PRG_BANK_RESET;
      cfg_ram_present = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset configuration
      for (int i = 0; i < DIR_ROWS; i++)
         send_word(dir_rows[i].kind, dir_rows[i].address, dir_rows[i].data,
                   dir_rows[i].typed, dir_rows[i].expected);
      run_random(230);

      // lowest last bank, no work ram
      drain_results();
      junk = 6'($urandom);
      write_csr(cbm_pkg::CSR_LAST_PRG_BANK, '0);
      write_csr(cbm_pkg::CSR_RAM_PRESENT, {junk[cbm_pkg::CSR_DATA_W-1:1], 1'b0});
      run_random(240);

      // highest last bank, still no ram; the receiver holds off while words keep coming
      drain_results();
      write_csr(cbm_pkg::CSR_LAST_PRG_BANK, 6'd63);
      sender_calm  = 1'b1;
      hold_results = 1'b1;
      repeat (40) send_lookup();
      sender_calm  = 1'b0;
      run_random(200);

      // a random last bank with ram back in
      drain_results();
      junk = 6'($urandom);
      write_csr(cbm_pkg::CSR_LAST_PRG_BANK, 6'($urandom));
      write_csr(cbm_pkg::CSR_RAM_PRESENT, {junk[cbm_pkg::CSR_DATA_W-1:1], 1'b1});
      run_random(240);

      // end of stimulus: wait for the tail, then keep watching for stray words
      drain_results();
      repeat (10) @(posedge clock);
      mismatches += expected_words.size();

      $display("run covered %0d request words and %0d result words", n_sent, n_checked);
      $display("%0d irq rises, %0d rom lookups, %0d configuration writes, %0d failures",
               n_irq_rises, n_lookups, n_settings, mismatches);
      if (mismatches == 0)
         $display("tb_cartridge_bank_mapper_irq_counter_unit passed");
      else
         $display("tb_cartridge_bank_mapper_irq_counter_unit failed");
      $finish;
   end

endmodule

// File: cartridge_bank_mapper_irq_counter_unit.f
+incdir+sv
sv/cbm_pkg.sv
sv/cbm_irq_counter.sv
sv/cbm_bank_regs.sv
sv/cartridge_bank_mapper_irq_counter_unit.sv
tb/tb_cartridge_bank_mapper_irq_counter_unit.sv
